@@ src/oaht_pkg.sv @@
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared widths, codes and defaults for the open-address hash table core.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

   // Default table geometry
   localparam int DEF_CAPACITY   = 256;
   localparam int DEF_KEY_BITS   = 32;
   localparam int DEF_VALUE_BITS = 64;

   // Fixed port widths
   localparam int OP_W       = 2;
   localparam int KEY_ID_W   = 32;
   localparam int HASH_W     = 32;
   localparam int VALUE_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int MAX_FILL_W = 8;

   localparam logic [MAX_FILL_W-1:0] MAX_FILL_RESET = 8'd192;

   // Hash reduction: bits folded into the remainder per cycle
   localparam int HASH_BITS_PER_STEP = 4;

   // Operation codes
   localparam logic [OP_W-1:0] OP_GET    = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   // Slot marks
   localparam int MARK_W = 2;
   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

endpackage

`default_nettype wire

@@ src/oaht_hash_index.sv @@
// ----------------------------------------------------------------------------
// oaht_hash_index
// Reduces a 32-bit hash to a home slot index (hash mod CAPACITY). A power of
// two capacity takes the low hash bits directly; any other capacity folds
// HASH_BITS_PER_STEP hash bits per cycle into a running remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_hash_index #(
   parameter int CAPACITY = oaht_pkg::DEF_CAPACITY
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire  [oaht_pkg::HASH_W-1:0]         hash,
   output logic                                done,
   output logic [$clog2(CAPACITY)-1:0]         index
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int ACC_W   = IDX_W + 1;
   localparam int STEP    = oaht_pkg::HASH_BITS_PER_STEP;
   localparam int ROUNDS  = oaht_pkg::HASH_W / STEP;
   localparam int ROUND_W = $clog2(ROUNDS);
   localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
   localparam logic [ACC_W-1:0] CAP_ACC = ACC_W'(CAPACITY);

   logic                          active_ff, active_in;
   logic                          done_ff, done_in;
   logic [ROUND_W-1:0]            round_ff, round_in;
   logic [oaht_pkg::HASH_W-1:0]   shift_ff, shift_in;
   logic [IDX_W-1:0]              rem_ff, rem_in;
   logic [IDX_W-1:0]              rem_step;

   // Fold STEP hash bits, MSB first, into the remainder
   always_comb begin
      logic [IDX_W-1:0] r;
      logic [ACC_W-1:0] t;
      r = rem_ff;
      for (int i = 0; i < STEP; i++) begin
         t = {r, shift_ff[oaht_pkg::HASH_W-1-i]};
         if (t >= CAP_ACC) begin
            t = t - CAP_ACC;
         end
         r = t[IDX_W-1:0];
      end
      rem_step = r;
   end

   // Sequencing
   always_comb begin
      active_in = active_ff;
      round_in  = round_ff;
      shift_in  = shift_ff;
      rem_in    = rem_ff;
      done_in   = 1'b0;
      if (start) begin
         if (IS_POW2) begin
            rem_in  = hash[IDX_W-1:0];
            done_in = 1'b1;
         end else begin
            shift_in  = hash;
            rem_in    = '0;
            round_in  = '0;
            active_in = 1'b1;
         end
      end else if (active_ff) begin
         rem_in   = rem_step;
         shift_in = shift_ff << STEP;
         round_in = round_ff + 1'b1;
         if (round_ff == ROUND_W'(ROUNDS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      round_ff <= round_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done  = done_ff;
   assign index = rem_ff;

endmodule

`default_nettype wire

@@ src/open_address_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// open_address_hash_table_core
// Fixed-capacity key/value table, open addressing with linear probing and
// tombstones, held in one synchronous slot memory.
// ----------------------------------------------------------------------------
// Usage: raise start with an operation while busy is low; the transfer
// happens at that edge. Exactly one result follows, shown for one cycle with
// rsp_strobe; it cannot be held off, so sample it when it appears. After
// reset the block runs a clearing pass over the slot memory, one slot per
// cycle, holding busy until every slot is marked empty. An operation first
// takes its home index from the hash (directly when CAPACITY is a power of
// two, by hash reduction otherwise), then walks the probe, one slot per cycle
// through the single registered read port, then writes back and reports;
// busy drops in the result cycle, so the next operation may be started then.
// The user must write max_fill through csr_ only while no operation is in
// progress; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module open_address_hash_table_core #(
   parameter int CAPACITY   = oaht_pkg::DEF_CAPACITY,
   parameter int KEY_BITS   = oaht_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = oaht_pkg::DEF_VALUE_BITS
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Command
   input  wire                                   start,
   output logic                                  busy,
   input  wire  [oaht_pkg::OP_W-1:0]             req_operation,
   input  wire  [oaht_pkg::KEY_ID_W-1:0]         req_key_id,
   input  wire  [oaht_pkg::HASH_W-1:0]           req_key_hash,
   input  wire  [oaht_pkg::VALUE_W-1:0]          req_value_in,
   // Result
   output logic                                  rsp_strobe,
   output logic [oaht_pkg::STATUS_W-1:0]         rsp_status,
   output logic [oaht_pkg::VALUE_W-1:0]          rsp_value_out,
   output logic                                  rsp_new_key,
   // Configuration
   input  wire                                   csr_write_enable,
   input  wire  [oaht_pkg::MAX_FILL_W-1:0]       csr_write_data
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = IDX_W + 1;
   localparam int KEY_W  = (KEY_BITS < oaht_pkg::KEY_ID_W) ? KEY_BITS : oaht_pkg::KEY_ID_W;
   localparam int VAL_W  = VALUE_BITS;
   localparam int MARK_W = oaht_pkg::MARK_W;
   localparam int WORD_W = MARK_W + KEY_W + VAL_W;
   localparam int CMP_W  = (CNT_W > oaht_pkg::MAX_FILL_W) ? CNT_W : oaht_pkg::MAX_FILL_W;

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_PROBE = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // Control state
   logic [2:0]                         state_ff, state_in;
   logic [oaht_pkg::MAX_FILL_W-1:0]    max_fill_ff, max_fill_in;
   logic [CNT_W-1:0]                   fill_ff, fill_in;
   logic [IDX_W-1:0]                   clr_idx_ff, clr_idx_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;

   // Operation context
   logic [oaht_pkg::OP_W-1:0]          op_ff, op_in;
   logic [KEY_W-1:0]                   key_ff, key_in;
   logic [VAL_W-1:0]                   val_ff, val_in;

   // Probe walk
   logic [IDX_W-1:0]                   addr_ff, addr_in;
   logic [CNT_W-1:0]                   issue_cnt_ff, issue_cnt_in;
   logic [CNT_W-1:0]                   exam_cnt_ff, exam_cnt_in;
   logic [IDX_W-1:0]                   rd_idx_ff, rd_idx_in;
   logic                               found_ff, found_in;
   logic [IDX_W-1:0]                   hit_idx_ff, hit_idx_in;
   logic [VAL_W-1:0]                   hit_val_ff, hit_val_in;
   logic                               tomb_vld_ff, tomb_vld_in;
   logic [IDX_W-1:0]                   tomb_idx_ff, tomb_idx_in;
   logic                               stop_vld_ff, stop_vld_in;
   logic [IDX_W-1:0]                   stop_idx_ff, stop_idx_in;

   // Result registers
   logic [oaht_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [oaht_pkg::VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                               rsp_new_ff, rsp_new_in;

   // Slot memory
   logic [WORD_W-1:0]                  slot_mem [CAPACITY];
   logic [WORD_W-1:0]                  mem_rdata_ff;
   logic                               mem_we;
   logic [IDX_W-1:0]                   mem_waddr;
   logic [WORD_W-1:0]                  mem_wdata;
   logic [IDX_W-1:0]                   rd_addr;
   logic [CNT_W-1:0]                   rd_addr_inc;
   logic [IDX_W-1:0]                   rd_addr_next;

   logic [MARK_W-1:0]                  rd_mark;
   logic [KEY_W-1:0]                   rd_key;
   logic [VAL_W-1:0]                   rd_val;
   logic                               fill_ok;

   logic                               mod_start;
   logic                               mod_done;
   logic [IDX_W-1:0]                   mod_index;

   // Home slot from the hash
   assign mod_start = (state_ff == S_IDLE) && start;

   oaht_hash_index #(
      .CAPACITY (CAPACITY)
   ) u_hash_index (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .hash  (req_key_hash),
      .done  (mod_done),
      .index (mod_index)
   );

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= slot_mem[rd_addr];
   end

   // Read address and wrap to the next slot
   assign rd_addr      = (state_ff == S_HASH) ? mod_index : addr_ff;
   assign rd_addr_inc  = {1'b0, rd_addr} + 1'b1;
   assign rd_addr_next = (rd_addr_inc == CNT_W'(CAPACITY)) ? '0 : rd_addr_inc[IDX_W-1:0];

   // Slot word fields
   assign rd_mark = mem_rdata_ff[WORD_W-1 -: MARK_W];
   assign rd_key  = mem_rdata_ff[VAL_W +: KEY_W];
   assign rd_val  = mem_rdata_ff[VAL_W-1:0];

   // Room for a slot taken from the empty region
   assign fill_ok = (CMP_W'(fill_ff) < CMP_W'(max_fill_ff)) && (fill_ff < CNT_W'(CAPACITY));

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      max_fill_in   = max_fill_ff;
      fill_in       = fill_ff;
      clr_idx_in    = clr_idx_ff;
      rd_vld_in     = 1'b0;
      rsp_strobe_in = 1'b0;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      addr_in       = addr_ff;
      issue_cnt_in  = issue_cnt_ff;
      exam_cnt_in   = exam_cnt_ff;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      tomb_vld_in   = tomb_vld_ff;
      tomb_idx_in   = tomb_idx_ff;
      stop_vld_in   = stop_vld_ff;
      stop_idx_in   = stop_idx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_new_in    = rsp_new_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_idx_ff;
      mem_wdata     = {oaht_pkg::MARK_EMPTY, {(KEY_W + VAL_W){1'b0}}};

      if (csr_write_enable) begin
         max_fill_in = csr_write_data;
      end

      case (state_ff)
         // Clearing pass: mark every slot empty
         S_CLEAR: begin
            mem_we     = 1'b1;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         // Take a command
         S_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               key_in   = req_key_id[KEY_W-1:0];
               val_in   = req_value_in[VAL_W-1:0];
               state_in = S_HASH;
            end
         end
         // Home slot ready: issue its read
         S_HASH: begin
            if (mod_done) begin
               rd_vld_in    = 1'b1;
               rd_idx_in    = rd_addr;
               addr_in      = rd_addr_next;
               issue_cnt_in = CNT_W'(1);
               exam_cnt_in  = '0;
               found_in     = 1'b0;
               tomb_vld_in  = 1'b0;
               stop_vld_in  = 1'b0;
               state_in     = S_PROBE;
            end
         end
         // Walk: read one slot ahead, check the slot read last cycle
         S_PROBE: begin
            if (issue_cnt_ff != CNT_W'(CAPACITY)) begin
               rd_vld_in    = 1'b1;
               rd_idx_in    = addr_ff;
               addr_in      = rd_addr_next;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               exam_cnt_in = exam_cnt_ff + 1'b1;
               if (rd_mark == oaht_pkg::MARK_EMPTY) begin
                  stop_vld_in = 1'b1;
                  stop_idx_in = rd_idx_ff;
                  state_in    = S_DONE;
               end else if ((rd_mark == oaht_pkg::MARK_LIVE) && (rd_key == key_ff)) begin
                  found_in   = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_val_in = rd_val;
                  state_in   = S_DONE;
               end else begin
                  // first tombstone passed is kept for insert
                  if ((rd_mark != oaht_pkg::MARK_LIVE) && !tomb_vld_ff) begin
                     tomb_vld_in = 1'b1;
                     tomb_idx_in = rd_idx_ff;
                  end
                  // every slot visited
                  if (exam_cnt_ff == CNT_W'(CAPACITY - 1)) begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         // Write back on a successful insert or remove, and report
         S_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = oaht_pkg::STATUS_ABSENT;
            rsp_value_in  = '0;
            rsp_new_in    = 1'b0;
            state_in      = S_IDLE;
            case (op_ff)
               oaht_pkg::OP_GET: begin
                  if (found_ff) begin
                     rsp_status_in = oaht_pkg::STATUS_OK;
                     rsp_value_in  = oaht_pkg::VALUE_W'(hit_val_ff);
                  end
               end
               oaht_pkg::OP_REMOVE: begin
                  if (found_ff) begin
                     mem_we        = 1'b1;
                     mem_waddr     = hit_idx_ff;
                     mem_wdata     = {oaht_pkg::MARK_TOMB, key_ff, {VAL_W{1'b0}}};
                     rsp_status_in = oaht_pkg::STATUS_OK;
                  end
               end
               oaht_pkg::OP_INSERT: begin
                  mem_wdata = {oaht_pkg::MARK_LIVE, key_ff, val_ff};
                  if (found_ff) begin
                     mem_we        = 1'b1;
                     mem_waddr     = hit_idx_ff;
                     rsp_status_in = oaht_pkg::STATUS_OK;
                  end else if (tomb_vld_ff) begin
                     mem_we        = 1'b1;
                     mem_waddr     = tomb_idx_ff;
                     rsp_status_in = oaht_pkg::STATUS_OK;
                     rsp_new_in    = 1'b1;
                  end else if (stop_vld_ff && fill_ok) begin
                     mem_we        = 1'b1;
                     mem_waddr     = stop_idx_ff;
                     fill_in       = fill_ff + 1'b1;
                     rsp_status_in = oaht_pkg::STATUS_OK;
                     rsp_new_in    = 1'b1;
                  end else begin
                     rsp_status_in = oaht_pkg::STATUS_FULL;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         max_fill_ff   <= oaht_pkg::MAX_FILL_RESET;
         fill_ff       <= '0;
         clr_idx_ff    <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_fill_ff   <= max_fill_in;
         fill_ff       <= fill_in;
         clr_idx_ff    <= clr_idx_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      addr_ff       <= addr_in;
      issue_cnt_ff  <= issue_cnt_in;
      exam_cnt_ff   <= exam_cnt_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_val_ff    <= hit_val_in;
      tomb_vld_ff   <= tomb_vld_in;
      tomb_idx_ff   <= tomb_idx_in;
      stop_vld_ff   <= stop_vld_in;
      stop_idx_ff   <= stop_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_new_ff    <= rsp_new_in;
   end

   // Outputs
   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_new_key   = rsp_new_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("command transfer did not start an operation");

   a_new_key_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_new_key) |-> (rsp_status == oaht_pkg::STATUS_OK))
      else $error("new key reported without success");

   a_value_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != oaht_pkg::STATUS_OK)) |-> (rsp_value_out == '0))
      else $error("value returned on a failed operation");

endmodule

`default_nettype wire
